/* hdl/hsw_pkg.sv */
// Shared types and constants for the fp16 hard-swish pipeline.
package hsw_pkg;

    // Side information that travels with each word down the pipe
    typedef struct packed {
        logic        vld;   // stage holds a word
        logic        spec;  // NaN or infinity input, result is fixed
        logic        sgn;   // sign of x, also the sign of a non-special result
        logic [15:0] sval;  // result for special inputs
    } t_tag;

    // clamp bounds in fixed point with 24 fraction bits
    localparam logic [26:0] C_THREE_FIX = 27'h300_0000;
    localparam logic [26:0] C_SIX_FIX   = 27'h600_0000;

    // significand of the binary32 constant 1/6 (0x3E2AAAAB), value K * 2^-26
    localparam logic [23:0] C_INV6_SIG  = 24'hAA_AAAB;

    // binary16 codes
    localparam logic [15:0] H_POS_INF   = 16'h7C00;
    localparam logic [15:0] H_DEF_NAN   = 16'h7E00;
    localparam logic [15:0] H_QUIET_BIT = 16'h0200;

endpackage

/* hdl/hsw_front.sv */
// Input decode, x + 3 in fixed point, binary32 rounding and clamp to [0, 6].
module hsw_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [15:0]      i_x,
    output hsw_pkg::t_tag    o_tag,
    output logic [10:0]      o_mx,
    output logic [4:0]       o_ex,
    output logic [26:0]      o_c
);

    logic               sgn;
    logic [4:0]         ef;
    logic [9:0]         man;
    logic               ge3;
    logic [10:0]        mx;
    logic [4:0]         ex;
    logic [26:0]        xfix;
    logic [26:0]        n_a_t;
    hsw_pkg::t_tag      n_a_tag;

    hsw_pkg::t_tag      r_a_tag;
    logic [10:0]        r_a_mx;
    logic [4:0]         r_a_ex;
    logic [26:0]        r_a_t;
    logic               r_a_lo;
    logic               r_a_hi;

    logic               g;
    logic               st;
    logic               lsb;
    logic [26:0]        unit;
    logic [26:0]        base;
    logic [26:0]        rnd;
    logic [26:0]        n_b_c;

    hsw_pkg::t_tag      r_b_tag;
    logic [10:0]        r_b_mx;
    logic [4:0]         r_b_ex;
    logic [26:0]        r_b_c;

    // decode: |x| = mx * 2^(ex-25)
    always_comb begin
        sgn  = i_x[15];
        ef   = i_x[14:10];
        man  = i_x[9:0];
        mx   = (ef == 5'd0) ? {1'b0, man} : {1'b1, man};
        ex   = (ef == 5'd0) ? 5'd1 : ef;
        ge3  = (ef > 5'd16) || ((ef == 5'd16) && (man >= 10'h200));
        xfix = 27'(mx) << (ex - 5'd1);
        n_a_t = sgn ? (hsw_pkg::C_THREE_FIX - xfix) : (hsw_pkg::C_THREE_FIX + xfix);
        n_a_tag.vld  = i_valid;
        n_a_tag.spec = (ef == 5'h1F);
        n_a_tag.sgn  = sgn;
        if (man != 10'd0) begin
            n_a_tag.sval = i_x | hsw_pkg::H_QUIET_BIT;
        end else if (sgn) begin
            n_a_tag.sval = hsw_pkg::H_DEF_NAN;
        end else begin
            n_a_tag.sval = hsw_pkg::H_POS_INF;
        end
    end

    // stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_a_tag.vld <= n_a_tag.vld;
        end
        if (i_en) begin
            r_a_tag.spec <= n_a_tag.spec;
            r_a_tag.sgn  <= n_a_tag.sgn;
            r_a_tag.sval <= n_a_tag.sval;
            r_a_mx       <= mx;
            r_a_ex       <= ex;
            r_a_t        <= n_a_t;
            r_a_lo       <= sgn & ge3;
            r_a_hi       <= ~sgn & ge3;
        end
    end

    // round t to 24 significant bits, nearest even, then clamp
    always_comb begin
        if (r_a_t[26]) begin
            g = r_a_t[2]; st = |r_a_t[1:0]; lsb = r_a_t[3];
            unit = 27'd8; base = {r_a_t[26:3], 3'b000};
        end else if (r_a_t[25]) begin
            g = r_a_t[1]; st = r_a_t[0]; lsb = r_a_t[2];
            unit = 27'd4; base = {r_a_t[26:2], 2'b00};
        end else if (r_a_t[24]) begin
            g = r_a_t[0]; st = 1'b0; lsb = r_a_t[1];
            unit = 27'd2; base = {r_a_t[26:1], 1'b0};
        end else begin
            g = 1'b0; st = 1'b0; lsb = 1'b0;
            unit = 27'd0; base = r_a_t;
        end
        rnd = base + ((g & (st | lsb)) ? unit : 27'd0);
        if (r_a_lo) begin
            n_b_c = 27'd0;
        end else if (r_a_hi) begin
            n_b_c = hsw_pkg::C_SIX_FIX;
        end else begin
            n_b_c = rnd;
        end
    end

    // stage B
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_b_tag.vld <= r_a_tag.vld;
        end
        if (i_en) begin
            r_b_tag.spec <= r_a_tag.spec;
            r_b_tag.sgn  <= r_a_tag.sgn;
            r_b_tag.sval <= r_a_tag.sval;
            r_b_mx       <= r_a_mx;
            r_b_ex       <= r_a_ex;
            r_b_c        <= n_b_c;
        end
    end

    assign o_tag = r_b_tag;
    assign o_mx  = r_b_mx;
    assign o_ex  = r_b_ex;
    assign o_c   = r_b_c;

    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_tag.vld |-> (r_b_c <= hsw_pkg::C_SIX_FIX))
        else $error("clamped operand above six");

endmodule

/* hdl/hsw_scale.sv */
// x * c and the product times 1/6, each rounded to binary32 nearest even.
module hsw_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  hsw_pkg::t_tag      i_tag,
    input  logic [10:0]        i_mx,
    input  logic [4:0]         i_ex,
    input  logic [26:0]        i_c,
    output hsw_pkg::t_tag      o_tag,
    output logic               o_zero,
    output logic [23:0]        o_sig,
    output logic signed [9:0]  o_exp
);

    hsw_pkg::t_tag      r_m_tag;
    logic [37:0]        r_m_q;
    logic [4:0]         r_m_ex;

    logic [5:0]         lead;
    logic [37:0]        nq;
    logic [24:0]        psum;
    logic               pinc;
    logic [23:0]        n_p_sig;
    logic signed [9:0]  n_p_exp;

    hsw_pkg::t_tag      r_p_tag;
    logic               r_p_zero;
    logic [23:0]        r_p_sig;
    logic signed [9:0]  r_p_exp;

    hsw_pkg::t_tag      r_r_tag;
    logic               r_r_zero;
    logic [47:0]        r_r_prod;
    logic signed [9:0]  r_r_exp;

    logic [23:0]        ykeep;
    logic               yg;
    logic               yst;
    logic [24:0]        ysum;
    logic [23:0]        n_y_sig;
    logic signed [9:0]  n_y_exp;

    hsw_pkg::t_tag      r_y_tag;
    logic               r_y_zero;
    logic [23:0]        r_y_sig;
    logic signed [9:0]  r_y_exp;

    // stage M: exact product, p = q * 2^(ex-49)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_m_tag.vld <= i_tag.vld;
        end
        if (i_en) begin
            r_m_tag.spec <= i_tag.spec;
            r_m_tag.sgn  <= i_tag.sgn;
            r_m_tag.sval <= i_tag.sval;
            r_m_q        <= 38'(i_mx) * 38'(i_c);
            r_m_ex       <= i_ex;
        end
    end

    // normalize and round the product to 24 bits
    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < 38; i++) begin
            if (r_m_q[i]) lead = 6'(i);
        end
        nq      = r_m_q << (6'd37 - lead);
        pinc    = nq[13] & ((|nq[12:0]) | nq[14]);
        psum    = {1'b0, nq[37:14]} + {24'd0, pinc};
        n_p_sig = psum[24] ? 24'h80_0000 : psum[23:0];
        n_p_exp = $signed({5'd0, r_m_ex}) + $signed({4'd0, lead})
                  - 10'sd72 + $signed({9'd0, psum[24]});
    end

    // stage P
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_p_tag.vld <= r_m_tag.vld;
        end
        if (i_en) begin
            r_p_tag.spec <= r_m_tag.spec;
            r_p_tag.sgn  <= r_m_tag.sgn;
            r_p_tag.sval <= r_m_tag.sval;
            r_p_zero     <= (r_m_q == 38'd0);
            r_p_sig      <= n_p_sig;
            r_p_exp      <= n_p_exp;
        end
    end

    // stage R: times the 1/6 significand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_r_tag.vld <= r_p_tag.vld;
        end
        if (i_en) begin
            r_r_tag.spec <= r_p_tag.spec;
            r_r_tag.sgn  <= r_p_tag.sgn;
            r_r_tag.sval <= r_p_tag.sval;
            r_r_zero     <= r_p_zero;
            r_r_prod     <= 48'(r_p_sig) * 48'(hsw_pkg::C_INV6_SIG);
            r_r_exp      <= r_p_exp;
        end
    end

    // round to 24 bits; leading one sits at bit 47 or 46
    always_comb begin
        if (r_r_prod[47]) begin
            ykeep = r_r_prod[47:24]; yg = r_r_prod[23]; yst = |r_r_prod[22:0];
        end else begin
            ykeep = r_r_prod[46:23]; yg = r_r_prod[22]; yst = |r_r_prod[21:0];
        end
        ysum    = {1'b0, ykeep} + {24'd0, yg & (yst | ykeep[0])};
        n_y_sig = ysum[24] ? 24'h80_0000 : ysum[23:0];
        n_y_exp = r_r_exp - 10'sd3 + $signed({9'd0, r_r_prod[47]})
                  + $signed({9'd0, ysum[24]});
    end

    // stage Y: y = sig * 2^exp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_y_tag.vld <= r_r_tag.vld;
        end
        if (i_en) begin
            r_y_tag.spec <= r_r_tag.spec;
            r_y_tag.sgn  <= r_r_tag.sgn;
            r_y_tag.sval <= r_r_tag.sval;
            r_y_zero     <= r_r_zero;
            r_y_sig      <= n_y_sig;
            r_y_exp      <= n_y_exp;
        end
    end

    assign o_tag  = r_y_tag;
    assign o_zero = r_y_zero;
    assign o_sig  = r_y_sig;
    assign o_exp  = r_y_exp;

    a_p_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_tag.vld && !r_p_tag.spec && !r_p_zero) |-> r_p_sig[23])
        else $error("product significand not normalized");

    a_y_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_y_tag.vld && !r_y_tag.spec && !r_y_zero) |-> r_y_sig[23])
        else $error("scaled significand not normalized");

    a_zero_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_p_tag.vld) |=> (r_r_zero == $past(r_p_zero)))
        else $error("zero flag lost between stages");

endmodule

/* hdl/hsw_narrow.sv */
// Binary32 to binary16 rounding (nearest even) and the output register.
module hsw_narrow (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  hsw_pkg::t_tag      i_tag,
    input  logic               i_zero,
    input  logic [23:0]        i_sig,
    input  logic signed [9:0]  i_exp,
    output logic               o_valid,
    output logic [15:0]        o_y
);

    logic signed [9:0]  e;
    logic signed [9:0]  sh;
    logic [47:0]        msh;
    logic [14:0]        q;
    logic               inc;
    logic [14:0]        mag;
    logic [15:0]        n_y;

    logic               r_vld;
    logic [15:0]        r_y;

    // biased half exponent of sig * 2^exp
    always_comb begin
        e   = i_exp + 10'sd38;
        sh  = 10'sd14 - e;
        msh = {i_sig, 24'd0} >> sh[4:0];
        q   = 15'd0;
        inc = 1'b0;
        mag = 15'd0;
        if (e >= 10'sd31) begin
            mag = hsw_pkg::H_POS_INF[14:0];
        end else if (e <= 10'sd0) begin
            if (sh <= 10'sd24) begin
                q   = msh[38:24];
                inc = msh[23] & ((|msh[22:0]) | msh[24]);
                mag = q + {14'd0, inc};
            end
        end else begin
            q   = {e[4:0], i_sig[22:13]};
            inc = i_sig[12] & ((|i_sig[11:0]) | i_sig[13]);
            mag = q + {14'd0, inc};
        end
        if (i_tag.spec) begin
            n_y = i_tag.sval;
        end else if (i_zero) begin
            n_y = {i_tag.sgn, 15'd0};
        end else begin
            n_y = {i_tag.sgn, mag};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y;
        end
    end

    assign o_valid = r_vld;
    assign o_y     = r_y;

endmodule

/* hdl/hard_swish_fp16_unit.sv */
// Top level of the fp16 hard-swish pipeline: y = x * clamp(x + 3, 0, 6) / 6.
//
//  channel | valid       | ready        | data
//  --------+-------------+--------------+---------
//  input   | i_in_valid  | o_in_ready   | i_x_in
//  output  | o_out_valid | i_out_ready  | o_y_out
//
// Seven register stages: decode/add, round/clamp, x*c, round, *1/6, round, narrow.
// One word per cycle while the output is not stalled; each word passes the seven
// registers in order, and o_out_valid rises when it reaches the narrow stage.
// Reset (synchronous, active low) clears only the stage valid bits.
// The whole pipe advances when the output register is empty or being taken,
// so a stall holds every stage in place and loses or repeats nothing.
module hard_swish_fp16_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_x_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_y_out
);

    logic               en;
    hsw_pkg::t_tag      f_tag;
    logic [10:0]        f_mx;
    logic [4:0]         f_ex;
    logic [26:0]        f_c;
    hsw_pkg::t_tag      s_tag;
    logic               s_zero;
    logic [23:0]        s_sig;
    logic signed [9:0]  s_exp;

    // global advance
    assign en         = ~o_out_valid | i_out_ready;
    assign o_in_ready = en;

    hsw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_x     (i_x_in),
        .o_tag   (f_tag),
        .o_mx    (f_mx),
        .o_ex    (f_ex),
        .o_c     (f_c)
    );

    hsw_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (f_tag),
        .i_mx    (f_mx),
        .i_ex    (f_ex),
        .i_c     (f_c),
        .o_tag   (s_tag),
        .o_zero  (s_zero),
        .o_sig   (s_sig),
        .o_exp   (s_exp)
    );

    hsw_narrow u_narrow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (s_tag),
        .i_zero  (s_zero),
        .i_sig   (s_sig),
        .i_exp   (s_exp),
        .o_valid (o_out_valid),
        .o_y     (o_y_out)
    );

endmodule
